// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ptb_pkg.sv
package ptb_pkg;

    localparam int TIMERS_DEF = 8;
    localparam int CNT_W      = 16;
    localparam int MASK_W     = 8;
    localparam int OP_W       = 3;
    localparam int IDX_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
    localparam logic [OP_W-1:0] OP_DISPATCH = 3'd1;
    localparam logic [OP_W-1:0] OP_RESET    = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY    = 3'd3;
    localparam logic [OP_W-1:0] OP_PERIOD   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ASYNC  = 2'd2;

    typedef struct packed {
        logic             wr;
        logic [CNT_W-1:0] count;
        logic             fire;
        logic             pend;
    } t_exp_upd;

endpackage

// File: rtl/periodic_timer_bank_core.sv
// Tick: one timer read per sweep cycle in SWEEP, then the DRAIN and DONE states;
// the result is registered as DONE exits to IDLE, and no new item is accepted before IDLE.
// Dispatch, reset, query and period write: result registered at the accept edge, one per cycle
// while not stalled: a new item is accepted only when idle and the output register is free.
// Reset (i_rst_n low, synchronous) clears masks, pending flags, entry valid bits
// and control; counts and periods read as zero until written.
module periodic_timer_bank_core #(
    parameter int TIMERS = ptb_pkg::TIMERS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [2:0] operation, [5:3] timer_index, [21:6] period_value
    input  logic [ptb_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [7:0] sync_fired, [15:8] async_dispatched, [23:16] pending_flags, [24] flag_set
    output logic [ptb_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [ptb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ptb_pkg::MASK_W-1:0]        i_cfg_wdata
);

    `include "assert_macros.svh"

    localparam int AW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam logic [ptb_pkg::MASK_W-1:0] BANK_MASK =
        ptb_pkg::MASK_W'((9'd1 << TIMERS) - 9'd1);
    localparam logic [ptb_pkg::IDX_W:0] TIMERS_X = (ptb_pkg::IDX_W + 1)'(TIMERS);
    localparam logic [AW-1:0] LAST_IDX = AW'(TIMERS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                    r_state;
    logic [AW-1:0]                 r_cnt;
    logic                          r_stg_v;
    logic [AW-1:0]                 r_stg_idx;
    logic [TIMERS-1:0]             r_cvld;
    logic [TIMERS-1:0]             r_pvld;
    logic [ptb_pkg::MASK_W-1:0]    r_en_mask;
    logic [ptb_pkg::MASK_W-1:0]    r_sync_mask;
    logic [ptb_pkg::MASK_W-1:0]    r_async_mask;
    logic [ptb_pkg::MASK_W-1:0]    r_pending;
    logic [ptb_pkg::MASK_W-1:0]    n_pending;
    logic [ptb_pkg::MASK_W-1:0]    r_fired;
    logic [ptb_pkg::MASK_W-1:0]    n_fired;
    logic                          r_out_valid;
    logic [ptb_pkg::OUT_DATA_W-1:0] r_out_data;

    logic [ptb_pkg::OP_W-1:0]      in_op;
    logic [ptb_pkg::IDX_W-1:0]     in_idx;
    logic [ptb_pkg::CNT_W-1:0]     in_per;
    logic                          idx_ok;
    logic                          out_free;
    logic                          in_acc;
    logic [ptb_pkg::MASK_W-1:0]    served;
    logic                          qflag;

    logic                          cnt_we;
    logic [AW-1:0]                 cnt_waddr;
    logic [ptb_pkg::CNT_W-1:0]     cnt_wdata;
    logic                          per_we;
    logic                          rd_en;
    logic [ptb_pkg::CNT_W-1:0]     cnt_rdata;
    logic [ptb_pkg::CNT_W-1:0]     per_rdata;
    logic [ptb_pkg::CNT_W-1:0]     cur_cnt;
    logic [ptb_pkg::CNT_W-1:0]     cur_per;
    ptb_pkg::t_exp_upd             upd;

    assign in_op  = i_s_axis_tdata[2:0];
    assign in_idx = i_s_axis_tdata[5:3];
    assign in_per = i_s_axis_tdata[21:6];
    assign idx_ok = {1'b0, in_idx} < TIMERS_X;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    assign served = r_pending & r_en_mask & r_async_mask & BANK_MASK;
    assign qflag  = idx_ok && r_pending[in_idx];

    assign rd_en     = (r_state == ST_SWEEP);
    assign cnt_we    = (in_acc && in_op == ptb_pkg::OP_RESET && idx_ok) || (r_stg_v && upd.wr);
    assign cnt_waddr = r_stg_v ? r_stg_idx : in_idx[AW-1:0];
    assign cnt_wdata = r_stg_v ? upd.count : '0;
    assign per_we    = in_acc && in_op == ptb_pkg::OP_PERIOD && idx_ok;

    ptb_ram #(.W(ptb_pkg::CNT_W), .DEPTH(TIMERS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (rd_en),
        .i_raddr (r_cnt),
        .o_rdata (cnt_rdata)
    );

    ptb_ram #(.W(ptb_pkg::CNT_W), .DEPTH(TIMERS)) u_per_ram (
        .i_clk   (i_clk),
        .i_we    (per_we),
        .i_waddr (in_idx[AW-1:0]),
        .i_wdata (in_per),
        .i_re    (rd_en),
        .i_raddr (r_cnt),
        .o_rdata (per_rdata)
    );

    // entries never written read as zero
    assign cur_cnt = r_cvld[r_stg_idx] ? cnt_rdata : '0;
    assign cur_per = r_pvld[r_stg_idx] ? per_rdata : '0;

    ptb_expiry u_expiry (
        .i_count    (cur_cnt),
        .i_period   (cur_per),
        .i_en       (r_en_mask[r_stg_idx]),
        .i_sync_en  (r_sync_mask[r_stg_idx]),
        .i_async_en (r_async_mask[r_stg_idx]),
        .o_upd      (upd)
    );

    always_comb begin
        n_pending = r_pending;
        n_fired   = r_fired;
        if (r_stg_v) begin
            if (upd.fire) begin
                n_fired[r_stg_idx] = 1'b1;
            end
            if (upd.pend) begin
                n_pending[r_stg_idx] = 1'b1;
            end
        end
        if (in_acc) begin
            case (in_op)
                ptb_pkg::OP_TICK: begin
                    n_fired = '0;
                end
                ptb_pkg::OP_DISPATCH: begin
                    n_pending = r_pending & ~served;
                end
                ptb_pkg::OP_RESET: begin
                    if (idx_ok) begin
                        n_pending[in_idx] = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_stg_v      <= 1'b0;
            r_cvld       <= '0;
            r_pvld       <= '0;
            r_en_mask    <= '0;
            r_sync_mask  <= '0;
            r_async_mask <= '0;
            r_pending    <= '0;
            r_fired      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pending <= n_pending;
            r_fired   <= n_fired;
            r_stg_v   <= rd_en;

            if (cnt_we) begin
                r_cvld[cnt_waddr] <= 1'b1;
            end
            if (per_we) begin
                r_pvld[in_idx[AW-1:0]] <= 1'b1;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ptb_pkg::CFG_ENABLE: r_en_mask    <= i_cfg_wdata;
                    ptb_pkg::CFG_SYNC:   r_sync_mask  <= i_cfg_wdata;
                    ptb_pkg::CFG_ASYNC:  r_async_mask <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc && in_op == ptb_pkg::OP_TICK) begin
                        r_cnt   <= '0;
                        r_state <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    if (r_cnt == LAST_IDX) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + AW'(1);
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (in_acc && in_op != ptb_pkg::OP_TICK) begin
                r_out_valid <= 1'b1;
            end else if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_stg_idx <= r_cnt;
        end
        if (in_acc && in_op != ptb_pkg::OP_TICK) begin
            r_out_data <= {7'd0,
                           (in_op == ptb_pkg::OP_QUERY) && qflag,
                           n_pending,
                           (in_op == ptb_pkg::OP_DISPATCH) ? served : 8'd0,
                           8'd0};
        end else if (r_state == ST_DONE && out_free) begin
            r_out_data <= {7'd0, 1'b0, r_pending, 8'd0, r_fired};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `ASSERT_NOW(a_no_wr_rd_clash, i_clk, i_rst_n, r_stg_v && rd_en, r_stg_idx != r_cnt, "sweep write hits read entry")
    `ASSERT_NEXT(a_tick_sweeps, i_clk, i_rst_n, in_acc && in_op == ptb_pkg::OP_TICK, r_state == ST_SWEEP, "tick did not start sweep")
    `ASSERT_NEXT(a_dispatch_clears, i_clk, i_rst_n, in_acc && in_op == ptb_pkg::OP_DISPATCH, (r_pending & r_out_data[15:8]) == 8'd0, "dispatched flag still pending")
    `ASSERT_NOW(a_pend_in_bank, i_clk, i_rst_n, r_out_valid, (r_out_data[23:16] & ~BANK_MASK) == 8'd0, "pending flag beyond bank")

endmodule

// File: rtl/ptb_ram.sv
module ptb_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                             i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [W-1:0]                             o_rdata
);

    logic [W-1:0] r_mem [0:DEPTH-1];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ptb_expiry.sv
module ptb_expiry (
    input  logic [ptb_pkg::CNT_W-1:0] i_count,
    input  logic [ptb_pkg::CNT_W-1:0] i_period,
    input  logic                      i_en,
    input  logic                      i_sync_en,
    input  logic                      i_async_en,
    output ptb_pkg::t_exp_upd         o_upd
);

    logic [ptb_pkg::CNT_W:0] next_cnt;
    logic                    hit;

    // one bit wider so the increment never wraps
    assign next_cnt = {1'b0, i_count} + {{ptb_pkg::CNT_W{1'b0}}, 1'b1};
    assign hit      = next_cnt >= {1'b0, i_period};

    always_comb begin
        o_upd.wr    = i_en;
        o_upd.count = hit ? '0 : next_cnt[ptb_pkg::CNT_W-1:0];
        o_upd.fire  = i_en && hit && i_sync_en;
        o_upd.pend  = i_en && hit && i_async_en;
    end

endmodule
